// File: hw/rtl/ppi_pkg.sv
// Shared types, codes and default sizes for the point-in-polygon block.
`timescale 1ns / 1ps

package ppi_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_BITS_DEF   = 32;

    localparam int FUNC_W   = 2;
    localparam int VIDX_W   = 6;
    localparam int VCOUNT_W = 7;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TEST  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_BOX   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;

    // word index of each register (byte address bits above the word offset)
    localparam logic [ADDR_W-3:0] REG_VCOUNT = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              shift;
        logic              wr;
        logic [VIDX_W-1:0] wr_idx;
    } t_cell_ctl;

    typedef struct packed {
        logic clr;
        logic feed;
    } t_edge_ctl;

endpackage

// File: hw/rtl/ppi_cell.sv
// One vertex slot of the circular vertex chain.
`timescale 1ns / 1ps

module ppi_cell #(
    parameter int COORD_BITS = ppi_pkg::COORD_BITS_DEF,
    parameter int INDEX      = 0
) (
    input  logic                         i_clk,
    input  ppi_pkg::t_cell_ctl           i_ctl,
    input  logic signed [COORD_BITS-1:0] i_wr_x,
    input  logic signed [COORD_BITS-1:0] i_wr_y,
    input  logic signed [COORD_BITS-1:0] i_nb_x,
    input  logic signed [COORD_BITS-1:0] i_nb_y,
    output logic signed [COORD_BITS-1:0] o_x,
    output logic signed [COORD_BITS-1:0] o_y
);

    logic signed [COORD_BITS-1:0] r_x;
    logic signed [COORD_BITS-1:0] r_y;
    logic                         w_hit;

    assign w_hit = i_ctl.wr && (32'(i_ctl.wr_idx) == INDEX);

    always_ff @(posedge i_clk) begin
        if (w_hit) begin
            r_x <= i_wr_x;
            r_y <= i_wr_y;
        end else if (i_ctl.shift) begin
            // take the neighbor's vertex, the ring rotates by one slot
            r_x <= i_nb_x;
            r_y <= i_nb_y;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

// File: hw/rtl/ppi_edge.sv
// Pipelined edge crossing test with exact cross-multiplied compare and parity.
`timescale 1ns / 1ps

module ppi_edge #(
    parameter int COORD_BITS = ppi_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ppi_pkg::t_edge_ctl           i_ctl,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    input  logic signed [COORD_BITS-1:0] i_x1,
    input  logic signed [COORD_BITS-1:0] i_y1,
    input  logic signed [COORD_BITS-1:0] i_x2,
    input  logic signed [COORD_BITS-1:0] i_y2,
    output logic                         o_parity,
    output logic                         o_busy
);

    localparam int B  = COORD_BITS + 1;
    localparam int L  = (B + 1) / 2;
    localparam int H  = B - L;
    localparam int PL = B + L + 1;
    localparam int PH = B + H;
    localparam int P  = 2 * B;

    // stage 1: differences and range check
    logic                w_en;
    logic signed [B-1:0] w_a, w_b, w_c, w_d;
    logic                r1_v, r1_pos;
    logic signed [B-1:0] r1_a, r1_b, r1_c, r1_d;
    // stage 2: partial products
    logic                r2_v, r2_pos;
    logic signed [PL-1:0] r2_ab_lo, r2_cd_lo;
    logic signed [PH-1:0] r2_ab_hi, r2_cd_hi;
    // stage 3: full products
    logic                r3_v, r3_pos;
    logic signed [P-1:0] r3_ab, r3_cd;
    logic                r_parity, n_parity;
    logic                w_cross;

    assign w_en = (i_y1 != i_y2)
               && (i_py >= ((i_y1 < i_y2) ? i_y1 : i_y2))
               && (i_py <  ((i_y1 > i_y2) ? i_y1 : i_y2));

    assign w_a = {i_py[COORD_BITS-1], i_py} - {i_y1[COORD_BITS-1], i_y1};
    assign w_b = {i_x2[COORD_BITS-1], i_x2} - {i_x1[COORD_BITS-1], i_x1};
    assign w_c = {i_px[COORD_BITS-1], i_px} - {i_x1[COORD_BITS-1], i_x1};
    assign w_d = {i_y2[COORD_BITS-1], i_y2} - {i_y1[COORD_BITS-1], i_y1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            r1_v <= i_ctl.feed && w_en;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_pos   <= i_y2 > i_y1;
        r1_a     <= w_a;
        r1_b     <= w_b;
        r1_c     <= w_c;
        r1_d     <= w_d;

        // split b and d into an unsigned low half and a signed high half
        r2_pos   <= r1_pos;
        r2_ab_lo <= r1_a * $signed({1'b0, r1_b[L-1:0]});
        r2_ab_hi <= r1_a * $signed(r1_b[B-1:L]);
        r2_cd_lo <= r1_c * $signed({1'b0, r1_d[L-1:0]});
        r2_cd_hi <= r1_c * $signed(r1_d[B-1:L]);

        r3_pos   <= r2_pos;
        r3_ab    <= (P'(r2_ab_hi) <<< L) + P'(r2_ab_lo);
        r3_cd    <= (P'(r2_cd_hi) <<< L) + P'(r2_cd_lo);
    end

    // crossing when (py-y1)*(x2-x1)/dy lies strictly right of px-x1
    assign w_cross = r3_pos ? (r3_ab > r3_cd) : (r3_ab < r3_cd);

    always_comb begin
        n_parity = r_parity;
        if (i_ctl.clr) begin
            n_parity = 1'b0;
        end else if (r3_v && w_cross) begin
            n_parity = ~r_parity;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity <= 1'b0;
        end else begin
            r_parity <= n_parity;
        end
    end

    assign o_parity = r_parity;
    assign o_busy   = r1_v || r2_v || r3_v;

endmodule

// File: hw/rtl/polygon_point_inclusion.sv
// Point-in-polygon crossing test and bounding box over a ring of vertex cells.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+--------------------------------------
//   input    | i_in_valid / o_in_ready      | i_func, i_vertex_index, i_coord_x/y
//   output   | o_out_valid / i_out_ready    | o_ok, o_inside_res, o_box_min/max_x/y
//   config   | psel, penable, pwrite, pready| paddr, pwdata, prdata (vertex_count)
//
// A vertex write or an unused func is accepted in idle and returns no result.
// A point test or box read rotates the vertex ring once, one vertex per cycle,
// MAX_VERTICES + 1 steps, then waits until the edge multiplier pipeline drains
// and loads the output register once it is free: input is ready again the cycle
// after the load. An empty polygon skips the ring and goes straight to the load.
// Reset clears control state and vertex_count; vertex cells hold no reset value.
// A stalled output blocks only the load of the next result.
`timescale 1ns / 1ps

module polygon_point_inclusion #(
    parameter int MAX_VERTICES = ppi_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = ppi_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input items
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ppi_pkg::FUNC_W-1:0]    i_func,
    input  logic [ppi_pkg::VIDX_W-1:0]    i_vertex_index,
    input  logic signed [COORD_BITS-1:0]  i_coord_x,
    input  logic signed [COORD_BITS-1:0]  i_coord_y,
    // results
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_ok,
    output logic                          o_inside_res,
    output logic signed [COORD_BITS-1:0]  o_box_min_x,
    output logic signed [COORD_BITS-1:0]  o_box_min_y,
    output logic signed [COORD_BITS-1:0]  o_box_max_x,
    output logic signed [COORD_BITS-1:0]  o_box_max_y,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ppi_pkg::ADDR_W-1:0]    paddr,
    input  logic [ppi_pkg::DATA_W-1:0]    pwdata,
    output logic [ppi_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int W  = COORD_BITS;

    ppi_pkg::t_state r_state, n_state;

    logic [ppi_pkg::VCOUNT_W-1:0] r_vcount;
    logic [NW-1:0]                w_used;
    logic [NW-1:0]                r_n;
    logic [NW-1:0]                r_step;
    logic                         r_box;
    logic signed [W-1:0]          r_px, r_py;
    logic signed [W-1:0]          r_first_x, r_first_y;
    logic signed [W-1:0]          r_prev_x, r_prev_y;
    logic signed [W-1:0]          r_mnx, r_mny, r_mxx, r_mxy;

    logic                         r_ovalid;
    logic                         r_ok, r_inside;
    logic signed [W-1:0]          r_omnx, r_omny, r_omxx, r_omxy;

    logic                         w_accept, w_query, w_run, w_load, w_last;
    logic                         w_cfg_wr;
    logic                         w_parity, w_busy;

    ppi_pkg::t_cell_ctl           w_cell_ctl;
    ppi_pkg::t_edge_ctl           w_edge_ctl;

    logic signed [W-1:0]          w_cx [MAX_VERTICES];
    logic signed [W-1:0]          w_cy [MAX_VERTICES];
    logic signed [W-1:0]          w_hx, w_hy, w_x2, w_y2;

    // ---------------- register port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                   && (paddr[ppi_pkg::ADDR_W-1:2] == ppi_pkg::REG_VCOUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= '0;
        end else if (w_cfg_wr) begin
            r_vcount <= pwdata[ppi_pkg::VCOUNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[ppi_pkg::ADDR_W-1:2] == ppi_pkg::REG_VCOUNT) begin
            prdata = ppi_pkg::DATA_W'(r_vcount);
        end
    end

    // clamp the count to the ring length
    assign w_used = (32'(r_vcount) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(r_vcount);

    // ---------------- sequencer ----------------
    assign w_accept = i_in_valid && o_in_ready;
    assign w_query  = (i_func == ppi_pkg::FUNC_TEST) || (i_func == ppi_pkg::FUNC_BOX);
    assign w_last   = (r_step == NW'(MAX_VERTICES));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ppi_pkg::ST_IDLE: begin
                if (w_accept && w_query) begin
                    n_state = (w_used == '0) ? ppi_pkg::ST_DONE : ppi_pkg::ST_RUN;
                end
            end
            ppi_pkg::ST_RUN: begin
                if (w_last) begin
                    n_state = ppi_pkg::ST_DRAIN;
                end
            end
            ppi_pkg::ST_DRAIN: begin
                if (!w_busy) begin
                    n_state = ppi_pkg::ST_DONE;
                end
            end
            ppi_pkg::ST_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    n_state = ppi_pkg::ST_IDLE;
                end
            end
            default: n_state = ppi_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        w_run      = 1'b0;
        w_load     = 1'b0;
        unique case (r_state)
            ppi_pkg::ST_IDLE:  o_in_ready = 1'b1;
            ppi_pkg::ST_RUN:   w_run      = 1'b1;
            ppi_pkg::ST_DRAIN: w_run      = 1'b0;
            ppi_pkg::ST_DONE:  w_load     = !r_ovalid || i_out_ready;
            default:           o_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppi_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- vertex ring ----------------
    always_comb begin
        w_cell_ctl.shift  = w_run && !w_last;
        w_cell_ctl.wr     = w_accept && (i_func == ppi_pkg::FUNC_WRITE);
        w_cell_ctl.wr_idx = i_vertex_index;
    end

    for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
        ppi_cell #(
            .COORD_BITS (COORD_BITS),
            .INDEX      (k)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_cell_ctl),
            .i_wr_x (i_coord_x),
            .i_wr_y (i_coord_y),
            .i_nb_x (w_cx[(k + 1) % MAX_VERTICES]),
            .i_nb_y (w_cy[(k + 1) % MAX_VERTICES]),
            .o_x    (w_cx[k]),
            .o_y    (w_cy[k])
        );
    end

    assign w_hx = w_cx[0];
    assign w_hy = w_cy[0];

    // ---------------- edge feed and box ----------------
    // the closing edge joins the last vertex in use back to the first
    assign w_x2 = (r_step == r_n) ? r_first_x : w_hx;
    assign w_y2 = (r_step == r_n) ? r_first_y : w_hy;

    always_comb begin
        w_edge_ctl.clr  = w_accept && w_query;
        w_edge_ctl.feed = w_run && !r_box && (r_step != '0) && (r_step <= r_n);
    end

    ppi_edge #(
        .COORD_BITS (COORD_BITS)
    ) u_edge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_edge_ctl),
        .i_px     (r_px),
        .i_py     (r_py),
        .i_x1     (r_prev_x),
        .i_y1     (r_prev_y),
        .i_x2     (w_x2),
        .i_y2     (w_y2),
        .o_parity (w_parity),
        .o_busy   (w_busy)
    );

    always_ff @(posedge i_clk) begin
        if (w_accept && w_query) begin
            r_px   <= i_coord_x;
            r_py   <= i_coord_y;
            r_box  <= (i_func == ppi_pkg::FUNC_BOX);
            r_n    <= w_used;
            r_step <= '0;
        end else if (w_run) begin
            r_step <= r_step + NW'(1);
            if (r_step < r_n) begin
                r_prev_x <= w_hx;
                r_prev_y <= w_hy;
            end
            if (r_step == '0) begin
                r_first_x <= w_hx;
                r_first_y <= w_hy;
                r_mnx     <= w_hx;
                r_mxx     <= w_hx;
                r_mny     <= w_hy;
                r_mxy     <= w_hy;
            end else if (r_step < r_n) begin
                if (w_hx < r_mnx) r_mnx <= w_hx;
                if (w_hx > r_mxx) r_mxx <= w_hx;
                if (w_hy < r_mny) r_mny <= w_hy;
                if (w_hy > r_mxy) r_mxy <= w_hy;
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ok     <= (r_n != '0);
            r_inside <= (r_n != '0) && !r_box && w_parity;
            r_omnx   <= ((r_n != '0) && r_box) ? r_mnx : '0;
            r_omny   <= ((r_n != '0) && r_box) ? r_mny : '0;
            r_omxx   <= ((r_n != '0) && r_box) ? r_mxx : '0;
            r_omxy   <= ((r_n != '0) && r_box) ? r_mxy : '0;
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_ok         = r_ok;
    assign o_inside_res = r_inside;
    assign o_box_min_x  = r_omnx;
    assign o_box_min_y  = r_omny;
    assign o_box_max_x  = r_omxx;
    assign o_box_max_y  = r_omxy;

endmodule

// File: hw/rtl/ppi_checker.sv
// Port-level checks for the point-in-polygon block, bound to the top level.
`timescale 1ns / 1ps

module ppi_checker #(
    parameter int COORD_BITS = ppi_pkg::COORD_BITS_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic                         o_ok,
    input logic                         o_inside_res,
    input logic signed [COORD_BITS-1:0] o_box_min_x,
    input logic signed [COORD_BITS-1:0] o_box_min_y,
    input logic signed [COORD_BITS-1:0] o_box_max_x,
    input logic signed [COORD_BITS-1:0] o_box_max_y
);

    // a stalled result stays valid and keeps ok, inside, box min x and box max y
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_inside_res)
            && $stable(o_ok) && $stable(o_box_min_x) && $stable(o_box_max_y))
        else $error("result changed while stalled");

    // an empty polygon reports nothing else
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_ok |-> !o_inside_res && o_box_min_x == '0
            && o_box_min_y == '0 && o_box_max_x == '0 && o_box_max_y == '0)
        else $error("empty polygon gave nonzero fields");

    // an inside result from a point test leaves the box fields clear
    a_inside_no_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_inside_res |-> o_ok && o_box_min_x == '0
            && o_box_min_y == '0 && o_box_max_x == '0 && o_box_max_y == '0)
        else $error("inside result with box fields set");

    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_box_min_x <= o_box_max_x && o_box_min_y <= o_box_max_y)
        else $error("bounding box min above max");

endmodule

bind polygon_point_inclusion ppi_checker #(
    .COORD_BITS (COORD_BITS)
) u_ppi_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_ok         (o_ok),
    .o_inside_res (o_inside_res),
    .o_box_min_x  (o_box_min_x),
    .o_box_min_y  (o_box_min_y),
    .o_box_max_x  (o_box_max_x),
    .o_box_max_y  (o_box_max_y)
);
